// ----- design/jc_pkg.sv -----
package jc_pkg;

  // Largest hole count the tables hold.
  localparam int MAX_HOLES = 1024;

  localparam int HOLE_W = 10;   // hole index width
  localparam int CNT_W  = 11;   // position, power and jump count width
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = $clog2(HOLE_W);

  localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] MAX_POS   = CNT_W'(MAX_HOLES);
  localparam logic [CNT_W-1:0] HOLE_RST  = CNT_W'(1024);
  localparam logic [CNT_W-1:0] BLOCK_RST = CNT_W'(32);

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLE_COUNT = 1'b0,
    REG_BLOCK_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SET_RT,
    ST_SET_CHK,
    ST_SET_RS,
    ST_Q_RS,
    ST_Q_S,
    ST_Q_T,
    ST_Q_OUT
  } state_t;

  // One shortcut entry: jumps to leave the block and the last hole inside it.
  typedef struct packed {
    logic [CNT_W-1:0]  exits;
    logic [HOLE_W-1:0] last;
  } shortcut_t;

endpackage

// ----- design/jc_if.sv -----
interface jc_cmd_if import jc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [HOLE_W-1:0] hole;
  logic [CNT_W-1:0]  power;

  modport source (output valid, output operation, output hole, output power, input ready);
  modport sink   (input valid, input operation, input hole, input power, output ready);
endinterface

interface jc_res_if import jc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HOLE_W-1:0] last_hole;
  logic [CNT_W-1:0]  jump_count;

  modport source (output valid, output last_hole, output jump_count, input ready);
  modport sink   (input valid, input last_hole, input jump_count, output ready);
endinterface

interface jc_cfg_if import jc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/block_shortcut_jump_chain.sv -----
// Channel | Dir | Payload                          | Transaction
// cfg     | in  | index, data                      | register write, always ready
// cmd     | in  | operation, hole, power           | one set or query item
// res     | out | last_hole, jump_count            | one result per query
//
// Set: store the target, compute hole mod block_size bit-serially, then walk
// down hole by hole to the block start. Query: accept, follow shortcuts (about
// hole_count/block_size of them) and finish by loading the output register.
// Each table has one registered read port and one write port. Synchronous reset
// clears control, presets config registers only; tables are undefined until written.
// A result waits in the output register; a query finishing while it is full stalls.
module block_shortcut_jump_chain import jc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  jc_cfg_if.sink   cfg,
  jc_cmd_if.sink   cmd,
  jc_res_if.source res
);

  // Configuration registers.
  logic [CNT_W-1:0] hole_count;
  logic [CNT_W-1:0] block_size;

  // Effective values: hole_count capped at the table depth, block_size of
  // zero behaves as one.
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] bs_eff;

  state_t state, state_next;

  // Target table and shortcut table, each with a registered read port.
  logic [CNT_W-1:0] tgt_mem [MAX_HOLES];
  shortcut_t        sc_mem  [MAX_HOLES];
  logic [CNT_W-1:0] tgt_rd;
  shortcut_t        sc_rd;

  logic [HOLE_W-1:0] tgt_ra, tgt_wa, sc_ra, sc_wa;
  logic [CNT_W-1:0]  tgt_wd;
  shortcut_t         sc_wd;
  logic              tgt_we, sc_we;

  // Item and walk registers.
  logic [HOLE_W-1:0]    op_hole;
  logic [HOLE_W-1:0]    j;
  logic [HOLE_W-1:0]    blk_start;
  logic [CNT_W:0]       blk_end;
  logic [CNT_W-1:0]     rem;
  logic [HOLE_W-1:0]    div_sh;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0]     qpos;
  logic [HOLE_W-1:0]    qlast;
  logic [CNT_W-1:0]     qcnt;

  // Output register.
  logic              res_valid;
  logic [HOLE_W-1:0] res_last;
  logic [CNT_W-1:0]  res_cnt;

  logic            cmd_take;
  logic            set_in_range;
  logic [CNT_W:0]  set_sum;
  logic [CNT_W-1:0] set_tgt;
  logic [CNT_W:0]  rem_sh;
  logic [CNT_W-1:0] rem_next;
  logic            exit_here;
  logic [CNT_W:0]  sc_inc;
  logic [CNT_W-1:0] sc_inc_sat;
  logic [CNT_W:0]  q_sum;
  logic [CNT_W-1:0] q_sum_sat;
  logic            walk_done;
  logic            res_free;

  assign n_eff  = (hole_count > MAX_POS) ? MAX_POS : hole_count;
  assign bs_eff = (block_size == '0) ? CNT_W'(1) : block_size;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;

  assign res.valid      = res_valid;
  assign res.last_hole  = res_last;
  assign res.jump_count = res_cnt;
  assign res_free       = !res_valid || res.ready;

  assign set_in_range = {1'b0, cmd.hole} < n_eff;
  assign set_sum      = {2'b0, cmd.hole} + {1'b0, cmd.power};
  assign set_tgt      = set_sum[CNT_W] ? CNT_SAT : set_sum[CNT_W-1:0];

  // One restoring division step on the hole index.
  assign rem_sh   = {rem, div_sh[HOLE_W-1]};
  assign rem_next = (rem_sh >= {1'b0, bs_eff}) ? CNT_W'(rem_sh - {1'b0, bs_eff})
                                               : rem_sh[CNT_W-1:0];

  // The target leaves the block when it exits the row, does not move forward,
  // or lands outside the block that holds the hole being refreshed.
  assign exit_here = (tgt_rd >= n_eff) || (tgt_rd <= {1'b0, j}) ||
                     (tgt_rd < {1'b0, blk_start}) || ({1'b0, tgt_rd} >= blk_end);

  assign sc_inc     = {1'b0, sc_rd.exits} + (CNT_W+1)'(1);
  assign sc_inc_sat = sc_inc[CNT_W] ? CNT_SAT : sc_inc[CNT_W-1:0];
  assign q_sum      = {1'b0, qcnt} + {1'b0, sc_rd.exits};
  assign q_sum_sat  = q_sum[CNT_W] ? CNT_SAT : q_sum[CNT_W-1:0];
  assign walk_done  = (j == blk_start);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      hole_count <= HOLE_RST;
      block_size <= BLOCK_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.index))
        REG_HOLE_COUNT: hole_count <= cfg.data;
        REG_BLOCK_SIZE: block_size <= cfg.data;
        default: ;
      endcase
    end
  end

  // Memories. Every read of an entry is issued only after the write that it
  // depends on, so the sequencing itself is the interlock.
  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_wa] <= tgt_wd;
    end
    tgt_rd <= tgt_mem[tgt_ra];
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[sc_wa] <= sc_wd;
    end
    sc_rd <= sc_mem[sc_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    tgt_ra = j;
    tgt_we = 1'b0;
    tgt_wa = cmd.hole;
    tgt_wd = set_tgt;
    sc_ra  = tgt_rd[HOLE_W-1:0];
    sc_we  = 1'b0;
    sc_wa  = j;
    sc_wd  = '{exits: CNT_W'(1), last: j};
    unique case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          if (op_t'(cmd.operation) == OP_QUERY) begin
            state_next = ST_Q_RS;
          end else if (set_in_range) begin
            tgt_we     = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_SET_RT;
        end
      end
      ST_SET_RT: begin
        state_next = ST_SET_CHK;
      end
      ST_SET_CHK: begin
        if (exit_here) begin
          sc_we      = 1'b1;
          state_next = walk_done ? ST_IDLE : ST_SET_RT;
        end else begin
          state_next = ST_SET_RS;
        end
      end
      ST_SET_RS: begin
        sc_we      = 1'b1;
        sc_wd      = '{exits: sc_inc_sat, last: sc_rd.last};
        state_next = walk_done ? ST_IDLE : ST_SET_RT;
      end
      ST_Q_RS: begin
        sc_ra      = qpos[HOLE_W-1:0];
        state_next = (qpos >= n_eff) ? ST_Q_OUT : ST_Q_S;
      end
      ST_Q_S: begin
        tgt_ra     = sc_rd.last;
        state_next = ST_Q_T;
      end
      ST_Q_T: begin
        state_next = (tgt_rd <= qpos) ? ST_Q_OUT : ST_Q_RS;
      end
      ST_Q_OUT: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_hole <= cmd.hole;
        j       <= cmd.hole;
        div_sh  <= cmd.hole;
        rem     <= '0;
        div_cnt <= DIV_CNT_W'(HOLE_W - 1);
        qpos    <= {1'b0, cmd.hole};
        qlast   <= cmd.hole;
        qcnt    <= '0;
      end
      ST_DIV: begin
        rem     <= rem_next;
        div_sh  <= {div_sh[HOLE_W-2:0], 1'b0};
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      ST_SET_RT: begin
        // rem is hole mod block size, so this is the first hole of the block.
        blk_start <= op_hole - rem[HOLE_W-1:0];
        blk_end   <= {2'b0, op_hole - rem[HOLE_W-1:0]} + {1'b0, bs_eff};
      end
      ST_SET_CHK: begin
        if (exit_here && !walk_done) begin
          j <= j - HOLE_W'(1);
        end
      end
      ST_SET_RS: begin
        if (!walk_done) begin
          j <= j - HOLE_W'(1);
        end
      end
      ST_Q_S: begin
        qcnt  <= q_sum_sat;
        qlast <= sc_rd.last;
      end
      ST_Q_T: begin
        if (tgt_rd > qpos) begin
          qpos <= tgt_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_Q_OUT && res_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_Q_OUT && res_free) begin
      res_last <= qlast;
      res_cnt  <= qcnt;
    end
  end

`ifndef SYNTHESIS
  // The downward walk never passes below the first hole of its block.
  a_walk_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SET_CHK || state == ST_SET_RS) |-> (j >= blk_start))
    else $error("shortcut walk left its block");

  // The walk returns to idle only once the block start is refreshed.
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SET_CHK || state == ST_SET_RS) && state_next == ST_IDLE) |-> walk_done)
    else $error("shortcut walk ended early");

  // Each division step leaves a remainder below the block size.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |=> (rem < bs_eff))
    else $error("remainder out of range");

  // A query chase moves strictly forward on every shortcut taken.
  a_chase_forward: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_T && state_next == ST_Q_RS) |=> (qpos > $past(qpos)))
    else $error("query chase did not advance");

  // A new result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_OUT && res_valid && !res.ready) |=> (state == ST_Q_OUT))
    else $error("result lost while output stalled");
`endif

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  import jc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch without any transaction on any channel before the run is
  // declared hung. It covers the slowest item, a set walking a whole 1024-hole
  // block or a query chasing every hole one jump at a time, plus the longest
  // sender gap, receiver stall and the settling pause between phases.
  localparam int STALL_LIMIT = 20000;
  localparam int GAP_MAX     = 18;
  localparam int POS_SAT     = 2047;

  // One expected query answer.
  typedef struct packed {
    logic [HOLE_W-1:0] last_hole;
    logic [CNT_W-1:0]  jump_count;
  } landing_t;

  logic clk;
  logic rst;

  jc_cfg_if cfg_if ();
  jc_cmd_if cmd_if ();
  jc_res_if res_if ();

  block_shortcut_jump_chain DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .cmd (cmd_if),
    .res (res_if)
  );

  // Shadow copy of the hole tables and the two geometry registers.
  logic [CNT_W-1:0]  target_of [MAX_HOLES];
  logic [CNT_W-1:0]  exits_of  [MAX_HOLES];
  logic [HOLE_W-1:0] last_of   [MAX_HOLES];
  logic [CNT_W-1:0]  holes_reg;
  logic [CNT_W-1:0]  block_reg;

  landing_t landing_q[$];
  int       mismatches;
  int       idle_cycles;
  bit       no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Holes at or beyond MAX_HOLES do not exist, so the row is clipped there.
  function automatic int row_length();
    return (holes_reg > MAX_POS) ? MAX_HOLES : int'(holes_reg);
  endfunction

  // A block size of zero behaves as one hole per block.
  function automatic int block_length();
    return (block_reg == '0) ? 1 : int'(block_reg);
  endfunction

  // Recompute the shortcut of one hole from its target. A target that
  // leaves the row, does not move forward, or lands in another block ends the
  // block walk right there; otherwise the hole inherits the target's shortcut
  // plus one jump.
  function automatic void refresh_shortcut(input int j, input int n, input int bs);
    int t;
    int c;
    t = int'(target_of[j]);
    if (t >= n || t <= j || (t / bs) != (j / bs)) begin
      exits_of[j] = CNT_W'(1);
      last_of[j]  = HOLE_W'(j);
    end else begin
      c = int'(exits_of[t]) + 1;
      exits_of[j] = CNT_W'((c > POS_SAT) ? POS_SAT : c);
      last_of[j]  = last_of[t];
    end
  endfunction

  // A set stores the new target and then walks down to the start of the
  // hole's block, since every lower hole in the block may route through it.
  function automatic void place_target(input logic [HOLE_W-1:0] hole,
                                       input logic [CNT_W-1:0] power);
    int n;
    int bs;
    int t;
    int first;
    int j;
    n  = row_length();
    bs = block_length();
    if (int'(hole) >= n) return;
    t = int'(hole) + int'(power);
    target_of[hole] = CNT_W'((t > POS_SAT) ? POS_SAT : t);
    first = (int'(hole) / bs) * bs;
    for (j = int'(hole); j >= first; j--) refresh_shortcut(j, n, bs);
  endfunction

  // Follow block shortcuts from a hole until the ball leaves the row. The
  // chase also stops when the next position would not move forward, which
  // keeps stale tables after a geometry change from looping.
  function automatic landing_t chase_ball(input logic [HOLE_W-1:0] hole);
    landing_t res;
    int n;
    int pos;
    int last;
    int cnt;
    int w;
    int nx;
    n    = row_length();
    pos  = int'(hole);
    last = int'(hole);
    cnt  = 0;
    while (pos < n) begin
      w    = int'(last_of[pos]);
      cnt  = cnt + int'(exits_of[pos]);
      if (cnt > POS_SAT) cnt = POS_SAT;
      last = w;
      nx   = int'(target_of[w]);
      if (nx <= pos) break;
      pos = nx;
    end
    res.last_hole  = HOLE_W'(last);
    res.jump_count = CNT_W'(cnt);
    return res;
  endfunction

  // Idle cycles before one transaction on either side. Zero is drawn often so
  // that back-to-back traffic mixes with gaps.
  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  // Mostly short jumps so that chains run through many holes and blocks, with
  // some long ones, the field extremes and a non-forward power of zero.
  function automatic logic [CNT_W-1:0] draw_power();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return CNT_W'($urandom_range(1, 6));
    if (pick < 80) return CNT_W'($urandom_range(7, 64));
    if (pick < 92) return CNT_W'($urandom_range(65, MAX_HOLES));
    if (pick < 94) return '0;
    if (pick < 96) return CNT_SAT;
    return CNT_W'($urandom_range(0, POS_SAT));
  endfunction

  // Holes inside the row most of the time, now and then anywhere in the field
  // so that out-of-range sets and queries show up.
  function automatic logic [HOLE_W-1:0] draw_hole();
    int n;
    n = row_length();
    if (n == 0 || $urandom_range(0, 9) == 0) return HOLE_W'($urandom_range(0, MAX_HOLES - 1));
    return HOLE_W'($urandom_range(0, n - 1));
  endfunction

  // Send one item and update the shadow tables at the edge that takes it.
  // Valid is left high on return so a following item without a gap goes out
  // back to back; whoever follows lowers it.
  task automatic send_item(input op_t op, input logic [HOLE_W-1:0] hole,
                           input logic [CNT_W-1:0] power);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.hole      <= hole;
    cmd_if.power     <= power;
    do @(posedge clk); while (!cmd_if.ready);
    if (op == OP_SET) place_target(hole, power);
    else landing_q.insert(landing_q.size(), chase_ball(hole));
  endtask

  // Stop sending and wait until every query answer has come back. The wait
  // always passes a clock edge, so valid never drops and rises within one time step.
  task automatic drain_landings();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (landing_q.size() != 0);
  endtask

  // A set produces no answer, so after the last answer one may still be
  // walking its block. Wait out the longest such walk for this geometry.
  task automatic settle_block();
    int walk;
    drain_landings();
    walk = (block_length() < row_length()) ? block_length() : row_length();
    repeat (40 + 4 * walk) @(posedge clk);
  endtask

  // Write both geometry registers back to back, only while the block is idle.
  task automatic write_geometry(input logic [CNT_W-1:0] holes,
                                input logic [CNT_W-1:0] block);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_HOLE_COUNT;
    cfg_if.data  <= holes;
    do @(posedge clk); while (!cfg_if.ready);
    holes_reg = holes;
    cfg_if.index <= REG_BLOCK_SIZE;
    cfg_if.data  <= block;
    do @(posedge clk); while (!cfg_if.ready);
    block_reg = block;
    cfg_if.valid <= 1'b0;
  endtask

  // Random mix of sets and queries under one geometry. Changing the geometry
  // leaves the shortcut tables stale, which the first queries of each phase
  // exercise before the sets rebuild the blocks they touch.
  task automatic run_phase(input logic [CNT_W-1:0] holes, input logic [CNT_W-1:0] block,
                           input int count, input bit burst);
    int k;
    op_t op;
    settle_block();
    write_geometry(holes, block);
    no_idle = burst;
    for (k = 0; k < count; k++) begin
      // Now and then hold the sender off until all answers are back.
      if ($urandom_range(0, 59) == 0) drain_landings();
      op = ($urandom_range(0, 99) < 45) ? OP_SET : OP_QUERY;
      send_item(op, draw_hole(),
                (op == OP_SET) ? draw_power() : CNT_W'($urandom_range(0, POS_SAT)));
    end
    no_idle = 1'b0;
  endtask

  // Hand-picked items on an eight-hole row: zero block size, a power of zero,
  // a power that saturates the stored target, sets and queries past the row,
  // then a block size change that leaves the shortcuts stale, and a set that
  // rebuilds the block.
  task automatic test_directed_cases();
    write_geometry(CNT_W'(8), '0);
    send_item(OP_SET, HOLE_W'(0), CNT_W'(1));
    send_item(OP_SET, HOLE_W'(1), '0);
    send_item(OP_SET, HOLE_W'(2), CNT_W'(2));
    send_item(OP_SET, HOLE_W'(3), CNT_W'(1));
    send_item(OP_SET, HOLE_W'(4), CNT_SAT);
    send_item(OP_SET, HOLE_W'(5), CNT_W'(1));
    send_item(OP_SET, HOLE_W'(6), CNT_W'(1));
    send_item(OP_SET, HOLE_W'(7), CNT_W'(MAX_HOLES));
    send_item(OP_SET, HOLE_W'(8), CNT_W'(1));
    send_item(OP_SET, HOLE_W'(MAX_HOLES - 1), CNT_SAT);
    send_item(OP_QUERY, HOLE_W'(0), '0);
    send_item(OP_QUERY, HOLE_W'(1), CNT_SAT);
    send_item(OP_QUERY, HOLE_W'(2), '0);
    send_item(OP_QUERY, HOLE_W'(7), '0);
    send_item(OP_QUERY, HOLE_W'(8), '0);
    send_item(OP_QUERY, HOLE_W'(MAX_HOLES - 1), '0);
    settle_block();
    write_geometry(CNT_W'(8), CNT_W'(8));
    send_item(OP_QUERY, HOLE_W'(0), '0);
    send_item(OP_QUERY, HOLE_W'(5), '0);
    send_item(OP_SET, HOLE_W'(6), CNT_W'(1));
    send_item(OP_QUERY, HOLE_W'(0), '0);
    send_item(OP_QUERY, HOLE_W'(2), '0);
  endtask

  // Write every hole once, in shuffled order, with one hole per block so no
  // set ever looks at a neighbor that has not been written yet. After this
  // any geometry and any item only touch written entries.
  task automatic test_fill_table();
    int order [MAX_HOLES];
    int k;
    int r;
    int tmp;
    for (k = 0; k < MAX_HOLES; k++) order[k] = k;
    for (k = MAX_HOLES - 1; k > 0; k--) begin
      r = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[r];
      order[r] = tmp;
    end
    settle_block();
    write_geometry(MAX_POS, CNT_W'(1));
    for (k = 0; k < MAX_HOLES; k++) send_item(OP_SET, HOLE_W'(order[k]), draw_power());
  endtask

  // The usual square-root geometry on the full row.
  task automatic test_default_geometry();
    run_phase(HOLE_RST, BLOCK_RST, 350, 1'b0);
    run_phase(CNT_W'(1024), CNT_W'(33), 150, 1'b0);
  endtask

  // One hole per block: every query follows every single jump.
  task automatic test_single_hole_blocks();
    run_phase(MAX_POS, CNT_W'(1), 80, 1'b0);
    run_phase(CNT_W'(517), '0, 40, 1'b0);
  endtask

  // One block spanning the row: every set walks all holes below it.
  task automatic test_whole_row_block();
    run_phase(MAX_POS, CNT_W'(1024), 40, 1'b0);
    run_phase(CNT_W'(1000), CNT_W'(1023), 30, 1'b0);
  endtask

  // Register values beyond the table size, all bits set.
  task automatic test_oversized_registers();
    run_phase(CNT_SAT, CNT_SAT, 30, 1'b0);
  endtask

  // A row of one hole, and an empty row where everything lies out of range.
  task automatic test_tiny_rows();
    run_phase(CNT_W'(1), CNT_W'(1), 30, 1'b0);
    run_phase('0, CNT_W'(7), 20, 1'b0);
  endtask

  // A stretch with neither side idling.
  task automatic test_back_to_back();
    run_phase(CNT_W'(300), CNT_W'(17), 150, 1'b1);
  endtask

  // Answer checker: takes every answer with its own random stall and compares
  // it against the oldest expected landing.
  initial begin
    int stall;
    landing_t want;
    res_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      if (stall == 0) begin
        res_if.ready <= 1'b1;
      end else begin
        // Hold ready low until an answer is offered, then keep it waiting.
        res_if.ready <= 1'b0;
        do @(posedge clk); while (!res_if.valid);
        repeat (stall - 1) @(posedge clk);
        res_if.ready <= 1'b1;
      end
      do @(posedge clk); while (!res_if.valid);
      if (landing_q.size() == 0) begin
        $display("%0t: answer with none expected, got last_hole %0d jump_count %0d",
                 $time, res_if.last_hole, res_if.jump_count);
        mismatches++;
      end else begin
        want = landing_q.pop_front();
        if (res_if.last_hole !== want.last_hole) begin
          $display("%0t: last_hole mismatch, expected %0d, got %0d",
                   $time, want.last_hole, res_if.last_hole);
          mismatches++;
        end
        if (res_if.jump_count !== want.jump_count) begin
          $display("%0t: jump_count mismatch, expected %0d, got %0d",
                   $time, want.jump_count, res_if.jump_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches       = 0;
    idle_cycles      = 0;
    no_idle          = 1'b0;
    holes_reg        = HOLE_RST;
    block_reg        = BLOCK_RST;
    cmd_if.valid     = 1'b0;
    cmd_if.operation = OP_SET;
    cmd_if.hole      = '0;
    cmd_if.power     = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_HOLE_COUNT;
    cfg_if.data      = '0;
    rst              = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_fill_table();
    test_default_geometry();
    test_single_hole_blocks();
    test_whole_row_block();
    test_oversized_registers();
    test_tiny_rows();
    test_back_to_back();

    // Wait for the last answers and for any set still walking its block.
    settle_block();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/jc_pkg.sv
design/jc_if.sv
design/block_shortcut_jump_chain.sv
sim/tb_top.sv
